[hdl/pcmfu_pkg.sv]
// Shared types, width codes and sample formatting for the stereo PCM frame unpacker.
package pcmfu_pkg;

   // Sample width codes, as written to the width register
   localparam logic [1:0] WIDTH_16 = 2'd0;
   localparam logic [1:0] WIDTH_24 = 2'd1;
   localparam logic [1:0] WIDTH_32 = 2'd2;

   localparam int unsigned FrameMaxBytes = 8;
   localparam int unsigned QueueDepth    = 2;

   // One completed frame: normalized width code and up to eight raw bytes
   typedef struct packed {
      logic [1:0]  width_code;
      logic [63:0] frame_data;
   } frame_type;

   // Fill state of the frame queue, seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Normalize a width code: the unused code acts as 16 bits
   function automatic logic [1:0] pcmfu_norm_width(input logic [1:0] code);
      logic [1:0] result;
      case (code)
         WIDTH_24: result = WIDTH_24;
         WIDTH_32: result = WIDTH_32;
         default:  result = WIDTH_16;
      endcase
      return result;
   endfunction

   // Index of the last byte of a frame for a given width code
   function automatic logic [2:0] pcmfu_last_index(input logic [1:0] code);
      logic [2:0] result;
      case (code)
         WIDTH_24: result = 3'd5;
         WIDTH_32: result = 3'd7;
         default:  result = 3'd3;
      endcase
      return result;
   endfunction

   // Left-justify both samples: right in the upper half, left in the lower
   function automatic logic [63:0] pcmfu_format(input frame_type frame);
      logic [63:0] b;
      logic [31:0] left;
      logic [31:0] right;
      b = frame.frame_data;
      case (frame.width_code)
         WIDTH_24: begin
            left  = {b[23:16], b[15:8], b[7:0], 8'h00};
            right = {b[47:40], b[39:32], b[31:24], 8'h00};
         end
         WIDTH_32: begin
            left  = b[31:0];
            right = b[63:32];
         end
         default: begin
            left  = {b[15:8], b[7:0], 16'h0000};
            right = {b[31:24], b[23:16], 16'h0000};
         end
      endcase
      return {right, left};
   endfunction

endpackage

[hdl/pcmfu_front.sv]
// Front end: accepts payload bytes, tracks the frame position and emits completed frames.
module pcmfu_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,   // [7:0] data_byte
   input  logic                      req_tlast,   // end_of_packet
   input  logic                      csr_wr_en,
   input  logic [1:0]                csr_wr_data, // sample_width_mode
   input  pcmfu_pkg::queue_status_type queue_status,
   output logic                      push_valid,
   output pcmfu_pkg::frame_type      push_frame
);
   import pcmfu_pkg::*;

   logic [1:0] width_ff;
   logic [1:0] width_in;
   logic [2:0] pos_ff;
   logic [2:0] pos_in;
   logic [7:0] bytes_ff [FrameMaxBytes-1];
   logic       accept;
   logic [2:0] last_idx;
   logic       complete;

   assign req_tready = !queue_status.full;
   assign accept     = req_tvalid && req_tready;
   assign last_idx   = pcmfu_last_index(width_ff);
   assign complete   = (pos_ff >= last_idx);

   // Assemble the frame: stored bytes, with this request as the last byte
   always_comb begin
      for (int i = 0; i < FrameMaxBytes - 1; i++) begin
         if (3'(i) == last_idx) begin
            push_frame.frame_data[8*i +: 8] = req_tdata;
         end else begin
            push_frame.frame_data[8*i +: 8] = bytes_ff[i];
         end
      end
      if (last_idx == 3'(FrameMaxBytes - 1)) begin
         push_frame.frame_data[63:56] = req_tdata;
      end else begin
         push_frame.frame_data[63:56] = 8'h00;
      end
      push_frame.width_code = pcmfu_norm_width(width_ff);
   end

   assign push_valid = accept && complete;

   // Width register
   assign width_in = csr_wr_en ? csr_wr_data : width_ff;

   // Advance the position; restart on a completed frame or at packet end
   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         if (complete || req_tlast) begin
            pos_in = 3'd0;
         end else begin
            pos_in = pos_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_16;
         pos_ff   <= 3'd0;
      end else begin
         width_ff <= width_in;
         pos_ff   <= pos_in;
      end
   end

   // Store a byte of an open frame
   always_ff @(posedge clock) begin
      if (accept && !complete) begin
         bytes_ff[pos_ff] <= req_tdata;
      end
   end

   // A completed frame restarts the position
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      push_valid |=> pos_ff == 3'd0)
      else $error("position not cleared after a completed frame");

   // Packet end always restarts the frame
   a_eop_restart: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> pos_ff == 3'd0)
      else $error("position not cleared at packet end");

endmodule

[hdl/pcmfu_queue.sv]
// Short frame queue between the front end and the output stage.
module pcmfu_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push_valid,
   input  pcmfu_pkg::frame_type        push_frame,
   input  logic                        pop,
   output pcmfu_pkg::frame_type        head_frame,
   output pcmfu_pkg::queue_status_type queue_status
);
   import pcmfu_pkg::*;

   localparam int unsigned PtrWidth = $clog2(QueueDepth);

   frame_type             entry_ff [QueueDepth];
   logic [PtrWidth-1:0]   wr_ptr_ff;
   logic [PtrWidth-1:0]   wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff;
   logic [PtrWidth-1:0]   rd_ptr_in;
   logic [PtrWidth:0]     count_ff;
   logic [PtrWidth:0]     count_in;
   logic                  do_push;
   logic                  do_pop;

   assign queue_status.full  = (count_ff == (PtrWidth+1)'(QueueDepth));
   assign queue_status.empty = (count_ff == '0);
   assign do_push = push_valid && !queue_status.full;
   assign do_pop  = pop && !queue_status.empty;
   assign head_frame = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_frame;
      end
   end

   // No frame may be offered while the queue is full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      queue_status.full |-> !push_valid)
      else $error("frame pushed into full queue");

   // Occupancy rises by one on a push without a pop
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not advance");

endmodule

[hdl/pcmfu_back.sv]
// Output stage: formats queued frames into left-justified samples and holds the response.
module pcmfu_back (
   input  logic                        clock,
   input  logic                        reset,
   input  pcmfu_pkg::frame_type        head_frame,
   input  pcmfu_pkg::queue_status_type queue_status,
   output logic                        pop,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [63:0]                 rsp_tdata  // [31:0] left_sample, [63:32] right_sample
);
   import pcmfu_pkg::*;

   logic        valid_ff;
   logic        valid_in;
   logic [63:0] data_ff;
   logic        load;

   // Refill the output register when empty or when the response is taken
   assign load     = !valid_ff || rsp_tready;
   assign pop      = load && !queue_status.empty;
   assign valid_in = load ? !queue_status.empty : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff <= pcmfu_format(head_frame);
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

   // A pop always leaves a response waiting
   a_pop_fills: assert property (@(posedge clock) disable iff (reset)
      pop |=> valid_ff)
      else $error("popped frame not presented");

endmodule

[hdl/pcm_stereo_frame_unpacker.sv]
// Top level of the stereo PCM frame unpacker.
//
// Usage:
//   The request channel (req_*) takes one byte of a little-endian interleaved
//   stereo PCM payload per transfer, with req_tlast on the last byte of the
//   packet. The response channel (rsp_*) gives one transfer per complete
//   frame: left sample in rsp_tdata[31:0], right in rsp_tdata[63:32], both
//   left-justified to signed 32 bits. csr_wr_en/csr_wr_data set the sample
//   width (0: 16 bits, 1: 24 bits, 2: 32 bits, 3: 16 bits); write only while
//   idle. A partial frame open at packet end is dropped.
// Timing:
//   One byte per clock while the queue is not full. A frame's last accepted
//   byte writes it into a two-entry frame queue; the output register loads
//   it from the queue once empty or once its held response is taken.
// Reset:
//   Synchronous; clears the width to 16 bits, the frame position, the queue
//   and the response valid. A stalled response holds while bytes keep
//   flowing; bytes stall only once the queue and output register are full.
module pcm_stereo_frame_unpacker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // end_of_packet
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] left_sample, [63:32] right_sample
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data  // sample_width_mode
);
   import pcmfu_pkg::*;

   logic             push_valid;
   frame_type        push_frame;
   frame_type        head_frame;
   logic             pop;
   queue_status_type queue_status;

   pcmfu_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .queue_status (queue_status),
      .push_valid   (push_valid),
      .push_frame   (push_frame)
   );

   pcmfu_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push_valid   (push_valid),
      .push_frame   (push_frame),
      .pop          (pop),
      .head_frame   (head_frame),
      .queue_status (queue_status)
   );

   pcmfu_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_frame   (head_frame),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the stereo PCM frame unpacker: directed table, random packets.
`timescale 1ns / 1ps

module tb_top;
   import pcmfu_pkg::*;

   // The unused width code behaves as 16 bits
   localparam logic [1:0] WIDTH_ALT16 = 2'd3;

   localparam int PhaseBytes   = 144;
   localparam int PhaseCount   = 8;
   localparam int SettleCycles = 4;
   localparam int DrainCycles  = 8;
   localparam int LongHold     = 60;
   localparam int StallLimit   = 2000;
   localparam int PrintLimit   = 40;

   // One directed request, with an optional hand-written frame result
   typedef struct packed {
      logic [1:0]  width;
      logic [7:0]  data;
      logic        last;
      logic        typed;
      logic [63:0] word;   // [31:0] left, [63:32] right
   } pcm_row_type;

   localparam int DirectedRows = 24;

   pcm_row_type directed_rows [DirectedRows] = '{
      '{WIDTH_16,    8'h00, 1'b0, 1'b0, 64'd0},
      '{WIDTH_16,    8'h00, 1'b0, 1'b0, 64'd0},
      '{WIDTH_16,    8'hFF, 1'b0, 1'b0, 64'd0},
      '{WIDTH_16,    8'hFF, 1'b0, 1'b1, {32'hFFFF0000, 32'h00000000}},
      '{WIDTH_16,    8'h00, 1'b0, 1'b0, 64'd0},
      '{WIDTH_16,    8'h80, 1'b0, 1'b0, 64'd0},
      '{WIDTH_16,    8'hFF, 1'b0, 1'b0, 64'd0},
      '{WIDTH_16,    8'h7F, 1'b0, 1'b1, {32'h7FFF0000, 32'h80000000}},
      // partial frame cut by the packet end: nothing comes out
      '{WIDTH_16,    8'h11, 1'b0, 1'b0, 64'd0},
      '{WIDTH_16,    8'h22, 1'b1, 1'b0, 64'd0},
      // frame that closes on the packet end still comes out
      '{WIDTH_ALT16, 8'hAA, 1'b0, 1'b0, 64'd0},
      '{WIDTH_ALT16, 8'hBB, 1'b0, 1'b0, 64'd0},
      '{WIDTH_ALT16, 8'hCC, 1'b0, 1'b0, 64'd0},
      '{WIDTH_ALT16, 8'hDD, 1'b1, 1'b1, {32'hDDCC0000, 32'hBBAA0000}},
      '{WIDTH_24,    8'h01, 1'b0, 1'b0, 64'd0},
      '{WIDTH_24,    8'h02, 1'b0, 1'b0, 64'd0},
      '{WIDTH_24,    8'h03, 1'b0, 1'b0, 64'd0},
      '{WIDTH_24,    8'h04, 1'b0, 1'b0, 64'd0},
      '{WIDTH_24,    8'h05, 1'b0, 1'b0, 64'd0},
      '{WIDTH_24,    8'h06, 1'b0, 1'b1, {32'h06050400, 32'h03020100}},
      // width drops from 32 to 16 bits in the middle of a frame
      '{WIDTH_32,    8'h5A, 1'b0, 1'b0, 64'd0},
      '{WIDTH_32,    8'hC3, 1'b0, 1'b0, 64'd0},
      '{WIDTH_32,    8'h96, 1'b0, 1'b0, 64'd0},
      '{WIDTH_16,    8'hE1, 1'b1, 1'b0, 64'd0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // [7:0] data_byte
   logic        req_tlast = 1'b0;   // end_of_packet
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;          // [31:0] left_sample, [63:32] right_sample
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_wr_data = 2'd0; // sample_width_mode

   // Hand-written result traveling with the current request
   logic        pinned_valid = 1'b0;
   logic [63:0] pinned_word = 64'd0;

   // Model state of the block
   logic [1:0]  model_width;
   logic [2:0]  model_pos;
   logic [55:0] model_bytes;
   logic [63:0] expected_frames [$];

   int  mismatch_count = 0;
   int  quiet_cycles = 0;
   bit  tx_idle_on = 1'b0;
   bit  rx_idle_on = 1'b0;
   bit  long_hold_go = 1'b0;

   pcm_stereo_frame_unpacker u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Index of the last byte of a frame for a width code
   function automatic logic [2:0] frame_last_index(input logic [1:0] width);
      logic [2:0] idx;
      case (width)
         WIDTH_24: idx = 3'd5;
         WIDTH_32: idx = 3'd7;
         default:  idx = 3'd3;
      endcase
      return idx;
   endfunction

   // Advance the model by one byte; return 1 with the frame word when a frame closes
   function automatic bit unpack_byte(input logic [7:0] data, input logic last,
                                      output logic [63:0] frame_word);
      logic [7:0]  b [8];
      logic [2:0]  last_idx;
      logic [31:0] left;
      logic [31:0] right;
      bit          done;
      last_idx = frame_last_index(model_width);
      done = 1'b0;
      frame_word = 64'd0;
      if (model_pos >= last_idx) begin
         for (int i = 0; i < 8; i++)
            b[i] = (i < 7) ? model_bytes[8*i +: 8] : 8'h00;
         b[last_idx] = data;
         case (model_width)
            WIDTH_24: begin
               left  = {b[2], b[1], b[0], 8'h00};
               right = {b[5], b[4], b[3], 8'h00};
            end
            WIDTH_32: begin
               left  = {b[3], b[2], b[1], b[0]};
               right = {b[7], b[6], b[5], b[4]};
            end
            default: begin
               left  = {b[1], b[0], 16'h0000};
               right = {b[3], b[2], 16'h0000};
            end
         endcase
         frame_word = {right, left};
         done = 1'b1;
         model_pos = 3'd0;
      end else begin
         model_bytes[8*model_pos +: 8] = data;
         model_pos = model_pos + 3'd1;
      end
      if (last)
         model_pos = 3'd0;
      return done;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      if (mismatch_count < PrintLimit)
         $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
      mismatch_count++;
   endtask

   // Check frames, predict frames from requests, track width writes, watch for a hang
   always @(posedge clock) begin : monitor
      logic [63:0] want;
      logic [63:0] word;
      bit          closes;
      if (reset) begin
         model_width = WIDTH_16;
         model_pos   = 3'd0;
         model_bytes = 56'd0;
         quiet_cycles = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_frames.size() == 0) begin
               report_mismatch("unexpected frame", 32'd0, rsp_tdata[31:0]);
            end else begin
               want = expected_frames.pop_front();
               if (rsp_tdata[31:0] !== want[31:0])
                  report_mismatch("left_sample", want[31:0], rsp_tdata[31:0]);
               if (rsp_tdata[63:32] !== want[63:32])
                  report_mismatch("right_sample", want[63:32], rsp_tdata[63:32]);
            end
         end
         if (req_tvalid && req_tready) begin
            closes = unpack_byte(req_tdata, req_tlast, word);
            if (pinned_valid)
               expected_frames.push_back(pinned_word);
            else if (closes)
               expected_frames.push_back(word);
         end
         if (csr_wr_en)
            model_width = csr_wr_data;
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= StallLimit) begin
            $display("pcm_stereo_frame_unpacker test failed");
            $finish;
         end
      end
   end

   // Receiver: random stall bursts, plus one long hold-off on request
   always @(posedge clock) begin : receiver
      static int  hold_left = 0;
      static int  stall_left = 0;
      static bit  hold_started = 1'b0;
      if (long_hold_go && !hold_started) begin
         hold_started = 1'b1;
         hold_left = LongHold;
      end
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left = $urandom_range(0, 3);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Offer one request and hold it until accepted
   task automatic send_byte(input logic [7:0] data, input logic last,
                            input logic typed, input logic [63:0] word);
      int gap;
      if (tx_idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 4);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid   <= 1'b1;
      req_tdata    <= data;
      req_tlast    <= last;
      pinned_valid <= typed;
      pinned_word  <= word;
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop valid, let the monitor see the last request, wait for every pending frame
   task automatic settle_block(input int extra);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic set_width(input logic [1:0] width);
      settle_block(SettleCycles);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= width;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Byte values leaning toward the sample extremes
   function automatic logic [7:0] pick_byte();
      logic [7:0] value;
      case ($urandom_range(0, 9))
         0:       value = 8'h00;
         1:       value = 8'hFF;
         2:       value = 8'h80;
         3:       value = 8'h7F;
         default: value = 8'($urandom_range(0, 255));
      endcase
      return value;
   endfunction

   initial begin : stimulus
      logic [1:0] phase_width [PhaseCount];
      logic [1:0] cur_width;
      logic [2:0] last_idx;
      int         phase_bytes;
      int         packet_len;
      int         kind;
      phase_width = '{WIDTH_32, WIDTH_ALT16, WIDTH_24, WIDTH_16,
                      WIDTH_32, WIDTH_24, WIDTH_ALT16, WIDTH_16};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table
      cur_width = WIDTH_16;
      foreach (directed_rows[r]) begin
         if (directed_rows[r].width != cur_width) begin
            cur_width = directed_rows[r].width;
            set_width(cur_width);
         end
         send_byte(directed_rows[r].data, directed_rows[r].last,
                   directed_rows[r].typed, directed_rows[r].word);
      end
      pinned_valid <= 1'b0;

      // Random packets, one width per phase; phases may end mid-frame
      for (int phase = 0; phase < PhaseCount; phase++) begin
         set_width(phase_width[phase]);
         last_idx = frame_last_index(phase_width[phase]);
         tx_idle_on = (phase != 3) && (phase != PhaseCount - 1) && ($urandom_range(0, 3) != 0);
         rx_idle_on <= (phase != PhaseCount - 1) && ($urandom_range(0, 3) != 0);
         if (phase == 3)
            long_hold_go <= 1'b1;
         phase_bytes = 0;
         while (phase_bytes < PhaseBytes) begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
               packet_len = $urandom_range(1, 20);
            else if (kind == 1)
               packet_len = $urandom_range(1, 5) * (last_idx + 1) + $urandom_range(1, last_idx);
            else
               packet_len = $urandom_range(1, 6) * (last_idx + 1);
            for (int i = 0; i < packet_len && phase_bytes < PhaseBytes; i++) begin
               send_byte(pick_byte(), i == packet_len - 1, 1'b0, 64'd0);
               phase_bytes++;
            end
         end
      end

      settle_block(DrainCycles);
      if (expected_frames.size() != 0)
         report_mismatch("missing frame", expected_frames[0][31:0], 32'd0);
      if (mismatch_count == 0)
         $display("pcm_stereo_frame_unpacker test passed");
      else
         $display("pcm_stereo_frame_unpacker test failed");
      $finish;
   end

endmodule

[files.f]
hdl/pcmfu_pkg.sv
hdl/pcmfu_front.sv
hdl/pcmfu_queue.sv
hdl/pcmfu_back.sv
hdl/pcm_stereo_frame_unpacker.sv
tb/tb_top.sv
